// File: rtl/i2c_master_transfer_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// I2C transfer sequencer assertion macros
// Shorthand for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define I2CSEQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2CSEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Shared types, codes and helpers for the front, queue and back.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	localparam int QueueDepth = 2;

	localparam int LenW    = 9;
	localparam int ByteW   = 8;
	localparam int AddrW   = 7;
	localparam int StoreAw = 8;
	localparam int StoreDepth = 1 << StoreAw;

	localparam logic [LenW-1:0] MaxBytes = 9'd256;
	localparam logic [AddrW-1:0] SlaveAddrReset = 7'h68;

	// input item kinds
	localparam logic [1:0] KindStart = 2'd0;
	localparam logic [1:0] KindEvent = 2'd1;
	localparam logic [1:0] KindLoad  = 2'd2;

	// controller flag bits
	localparam int FlagSb   = 0;
	localparam int FlagAddr = 1;
	localparam int FlagRxne = 2;
	localparam int FlagTxe  = 3;
	localparam int FlagBtf  = 4;

	// configuration register indexes
	localparam logic [1:0] RegSlaveAddr = 2'd0;
	localparam logic [1:0] RegWriteLen  = 2'd1;
	localparam logic [1:0] RegReadLen   = 2'd2;
	localparam logic [1:0] RegCircular  = 2'd3;

	// ack / buffer irq control codes
	localparam logic [1:0] CtlKeep = 2'd0;
	localparam logic [1:0] CtlOn   = 2'd1;
	localparam logic [1:0] CtlOff  = 2'd2;

	// reported transfer state codes
	localparam logic [1:0] TsIdle  = 2'd0;
	localparam logic [1:0] TsBusy  = 2'd1;
	localparam logic [1:0] TsDone  = 2'd2;
	localparam logic [1:0] TsError = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_START = 3'd1,
		EV_LOAD  = 3'd2,
		EV_SB    = 3'd3,
		EV_ADDR  = 3'd4,
		EV_RXNE  = 3'd5,
		EV_TXE   = 3'd6,
		EV_BTF   = 3'd7
	} ev_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_BUSY  = 4'b0010,
		ST_DONE  = 4'b0100,
		ST_ERROR = 4'b1000
	} status_t;

	typedef struct packed {
		ev_t               ev;
		logic              btf;
		logic [ByteW-1:0]  data;
		logic [StoreAw-1:0] idx;
	} qent_t;

	typedef struct packed {
		logic             wr;
		logic [1:0]       index;
		logic [LenW-1:0]  data;
	} cfg_wr_t;

	typedef struct packed {
		logic             send_valid;
		logic [ByteW-1:0] send_byte;
		logic             request_start;
		logic             request_stop;
		logic [1:0]       ack_control;
		logic [1:0]       buffer_irq_control;
		logic             recv_valid;
		logic [ByteW-1:0] recv_index;
		logic [ByteW-1:0] recv_byte;
		logic [1:0]       transfer_state;
		logic             done_pulse;
	} result_t;

	function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
		return (v > MaxBytes) ? MaxBytes : v;
	endfunction

	function automatic logic [1:0] status_code(input status_t s);
		logic [1:0] c;
		unique case (s)
			ST_IDLE:  c = TsIdle;
			ST_BUSY:  c = TsBusy;
			ST_DONE:  c = TsDone;
			ST_ERROR: c = TsError;
			default:  c = TsIdle;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/i2cseq_front.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer front
// Accepts items and reduces them to one event code by flag priority.
// ----------------------------------------------------------------------------
module i2cseq_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           kind,
	input  logic [4:0]           status_flags,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           load_index,
	input  logic                 q_full,
	output logic                 push,
	output i2cseq_pkg::qent_t    push_ent
);
	import i2cseq_pkg::*;

	ev_t ev;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		ev = EV_NONE;
		if (kind == KindStart) begin
			ev = EV_START;
		end else if (kind == KindLoad) begin
			ev = EV_LOAD;
		end else if (kind == KindEvent) begin
			// start sent > address sent > rx not empty > tx empty > byte finished
			priority if (status_flags[FlagSb])   ev = EV_SB;
			else if (status_flags[FlagAddr])     ev = EV_ADDR;
			else if (status_flags[FlagRxne])     ev = EV_RXNE;
			else if (status_flags[FlagTxe])      ev = EV_TXE;
			else if (status_flags[FlagBtf])      ev = EV_BTF;
			else                                 ev = EV_NONE;
		end
	end

	assign push_ent.ev   = ev;
	assign push_ent.btf  = status_flags[FlagBtf];
	assign push_ent.data = data_byte;
	assign push_ent.idx  = load_index;

endmodule

// File: rtl/i2cseq_queue.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer queue
// Small FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module i2cseq_queue #(
	parameter int DEPTH = i2cseq_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  i2cseq_pkg::qent_t    push_ent,
	input  logic                 pop,
	output i2cseq_pkg::qent_t    head,
	output logic                 nonempty,
	output logic                 full
);
	import i2cseq_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	qent_t             ent_q [DEPTH];
	logic [PtrW-1:0]   wptr_q;
	logic [PtrW-1:0]   rptr_q;
	logic [CntW-1:0]   count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign nonempty = (count_q != '0);
	assign full     = (count_q == CntW'(DEPTH));
	assign head     = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wptr_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= ptr_inc(wptr_q);
			if (pop)  rptr_q <= ptr_inc(rptr_q);
			if (push && !pop)      count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

endmodule

// File: rtl/i2cseq_back.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer back
// Executes one event per cycle, unless the output stalls, against the transfer
// state; owns the config registers and write byte store and holds the result.
// ----------------------------------------------------------------------------
module i2cseq_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2cseq_pkg::cfg_wr_t  cfg,
	input  logic                 q_nonempty,
	input  i2cseq_pkg::qent_t    head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output i2cseq_pkg::result_t  res_out,
	output logic                 err_state
);
	import i2cseq_pkg::*;

	// configuration
	logic [AddrW-1:0] addr_q;
	logic [LenW-1:0]  wlen_q;
	logic [LenW-1:0]  rlen_q;
	logic             circ_q;

	// transfer state
	logic [LenW-1:0]  wrem_q;
	logic [LenW-1:0]  rrem_q;
	logic             wact_q;
	logic             ract_q;
	status_t          status_q;

	// next-state and result of the head item
	logic [LenW-1:0]  n_wrem, n_rrem;
	logic             n_wact, n_ract;
	status_t          n_status;
	result_t          res;
	logic             err, wdone, rdone, from_store;
	logic [LenW-1:0]  w_off, r_off;

	// output register and store read data
	logic             valid_s2;
	result_t          res_s2;
	logic             from_store_s2;
	logic [ByteW-1:0] store_mem [StoreDepth];
	logic [ByteW-1:0] rdata_q;

	assign pop       = q_nonempty && (!valid_s2 || out_ready);
	assign out_valid = valid_s2;
	assign err_state = (status_q == ST_ERROR);

	assign w_off = wlen_q - wrem_q;
	assign r_off = rlen_q - rrem_q;

	always_comb begin
		n_wrem     = wrem_q;
		n_rrem     = rrem_q;
		n_wact     = wact_q;
		n_ract     = ract_q;
		n_status   = status_q;
		res        = '0;
		err        = 1'b0;
		from_store = 1'b0;
		wdone      = 1'b0;
		rdone      = 1'b0;

		unique case (head.ev)
			EV_START: begin
				n_status          = ST_BUSY;
				res.request_start = 1'b1;
			end
			EV_SB, EV_ADDR, EV_RXNE, EV_TXE, EV_BTF: begin
				if (status_q != ST_ERROR) begin
					if (wact_q) begin
						unique case (head.ev)
							EV_SB: begin
								res.send_valid = 1'b1;
								res.send_byte  = {addr_q, 1'b0};
							end
							EV_ADDR: res.buffer_irq_control = CtlOn;
							EV_TXE: begin
								if (wrem_q != '0) begin
									if (wrem_q > wlen_q) begin
										err = 1'b1;
									end else begin
										res.send_valid = 1'b1;
										from_store     = 1'b1;
										n_wrem         = wrem_q - LenW'(1);
									end
								end else if (head.btf) begin
									res.buffer_irq_control = CtlOff;
									if (ract_q && rrem_q != '0) res.request_start = 1'b1;
									else                        res.request_stop  = 1'b1;
									n_wact = 1'b0;
								end
							end
							default: ;
						endcase
					end else if (ract_q) begin
						unique case (head.ev)
							EV_SB: begin
								res.send_valid = 1'b1;
								res.send_byte  = {addr_q, 1'b1};
							end
							EV_ADDR: begin
								res.ack_control        = CtlOn;
								res.buffer_irq_control = CtlOn;
								if (rlen_q == LenW'(1)) begin
									if (rrem_q > rlen_q || rrem_q == '0) begin
										err = 1'b1;
									end else begin
										res.ack_control  = CtlOff;
										res.request_stop = 1'b1;
									end
								end
							end
							EV_RXNE: begin
								if (rrem_q != '0) begin
									if (rrem_q > rlen_q) begin
										err = 1'b1;
									end else begin
										// NACK and stop go out ahead of the last byte
										if (rrem_q == LenW'(2)) begin
											res.ack_control  = CtlOff;
											res.request_stop = 1'b1;
										end
										res.recv_valid = 1'b1;
										res.recv_index = r_off[ByteW-1:0];
										res.recv_byte  = head.data;
										n_rrem         = rrem_q - LenW'(1);
										if (rrem_q == LenW'(1)) begin
											res.buffer_irq_control = CtlOff;
											n_ract = 1'b0;
										end
									end
								end
							end
							default: ;
						endcase
					end

					if (err) begin
						n_status = ST_ERROR;
					end else begin
						wdone = !n_wact || n_wrem == '0;
						rdone = !n_ract || n_rrem == '0;
						if (wdone && rdone && status_q == ST_BUSY) begin
							n_status       = ST_DONE;
							res.done_pulse = 1'b1;
							if (circ_q) begin
								n_wrem            = wlen_q;
								n_wact            = (wlen_q != '0);
								n_rrem            = rlen_q;
								n_ract            = (rlen_q != '0);
								n_status          = ST_BUSY;
								res.request_start = 1'b1;
							end
						end
					end
				end
			end
			EV_LOAD, EV_NONE: ;
			default: ;
		endcase

		res.transfer_state = status_code(n_status);
	end

	// write byte store, one write or one read per executed item
	always_ff @(posedge clk) begin
		if (pop && head.ev == EV_LOAD) store_mem[head.idx] <= head.data;
		if (pop && from_store)         rdata_q <= store_mem[w_off[StoreAw-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_s2        <= res;
			from_store_s2 <= from_store;
		end
	end

	always_comb begin
		res_out = res_s2;
		if (from_store_s2) res_out.send_byte = rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			addr_q   <= SlaveAddrReset;
			wlen_q   <= '0;
			rlen_q   <= '0;
			circ_q   <= 1'b0;
			wrem_q   <= '0;
			rrem_q   <= '0;
			wact_q   <= 1'b0;
			ract_q   <= 1'b0;
			status_q <= ST_IDLE;
		end else begin
			if (pop)            valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;

			if (pop) begin
				wrem_q   <= n_wrem;
				rrem_q   <= n_rrem;
				wact_q   <= n_wact;
				ract_q   <= n_ract;
				status_q <= n_status;
			end

			// user must keep these written only while idle, so no overlap with an executing item; unenforced here
			if (cfg.wr) begin
				unique case (cfg.index)
					RegSlaveAddr: addr_q <= cfg.data[AddrW-1:0];
					RegWriteLen: begin
						wlen_q <= clamp_len(cfg.data);
						wrem_q <= clamp_len(cfg.data);
						wact_q <= (clamp_len(cfg.data) != '0);
					end
					RegReadLen: begin
						rlen_q <= clamp_len(cfg.data);
						rrem_q <= clamp_len(cfg.data);
						ract_q <= (clamp_len(cfg.data) != '0);
					end
					RegCircular: circ_q <= cfg.data[0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: rtl/i2c_master_transfer_sequencer_core.sv
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core
// Drives an I2C master controller through a write then repeated-start read,
// one controller event per item.
//
// Channel  Handshake            Payload
// in       in_valid/in_ready    kind, status_flags, data_byte, load_index
// out      out_valid/out_ready  send_*, request_*, *_control, recv_*, state
// cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Sustained rate is one item per cycle while out is not stalled; the single
// execute stage with one store read per item sets it. Results are registered.
// A queue of QUEUE_DEPTH items absorbs output stalls; in_ready drops when
// it is full. cfg_ready is always high.
// Reset clears control and configuration; the write store is not cleared.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_core_assert.svh"

module i2c_master_transfer_sequencer_core #(
	parameter int QUEUE_DEPTH = i2cseq_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [4:0]  status_flags,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  load_index,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        send_valid,
	output logic [7:0]  send_byte,
	output logic        request_start,
	output logic        request_stop,
	output logic [1:0]  ack_control,
	output logic [1:0]  buffer_irq_control,
	output logic        recv_valid,
	output logic [7:0]  recv_index,
	output logic [7:0]  recv_byte,
	output logic [1:0]  transfer_state,
	output logic        done_pulse
);
	import i2cseq_pkg::*;

	qent_t   push_ent, head;
	logic    push, pop, q_nonempty, q_full, err_state;
	cfg_wr_t cfg;
	result_t res;

	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	i2cseq_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.status_flags (status_flags),
		.data_byte    (data_byte),
		.load_index   (load_index),
		.q_full       (q_full),
		.push         (push),
		.push_ent     (push_ent)
	);

	i2cseq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.nonempty (q_nonempty),
		.full     (q_full)
	);

	i2cseq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res_out    (res),
		.err_state  (err_state)
	);

	assign send_valid         = res.send_valid;
	assign send_byte          = res.send_byte;
	assign request_start      = res.request_start;
	assign request_stop       = res.request_stop;
	assign ack_control        = res.ack_control;
	assign buffer_irq_control = res.buffer_irq_control;
	assign recv_valid         = res.recv_valid;
	assign recv_index         = res.recv_index;
	assign recv_byte          = res.recv_byte;
	assign transfer_state     = res.transfer_state;
	assign done_pulse         = res.done_pulse;

	`I2CSEQ_ASSERT_NOW(a_send_recv_excl, out_valid, !(send_valid && recv_valid), "send and receive in one result")
	`I2CSEQ_ASSERT_NOW(a_done_state, out_valid && done_pulse, transfer_state == TsDone || transfer_state == TsBusy, "done pulse with wrong state")
	`I2CSEQ_ASSERT_NEXT(a_err_sticky, err_state && !(pop && head.ev == EV_START), err_state, "error left without start request")

endmodule

// File: test/i2c_master_transfer_sequencer_core_checker.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer checker
// Watches the input, config and result channels of the sequencer. Keeps its
// own copy of the transfer state and write store, predicts the result of
// every accepted item, and compares each delivered result in order.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core_checker
	import i2cseq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [4:0]  status_flags,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  load_index,

	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,

	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        send_valid,
	input  logic [7:0]  send_byte,
	input  logic        request_start,
	input  logic        request_stop,
	input  logic [1:0]  ack_control,
	input  logic [1:0]  buffer_irq_control,
	input  logic        recv_valid,
	input  logic [7:0]  recv_index,
	input  logic [7:0]  recv_byte,
	input  logic [1:0]  transfer_state,
	input  logic        done_pulse,

	output int          mismatches,
	output int          outstanding
);

	// predicted sequencer state
	logic [ByteW-1:0] tx_bytes [StoreDepth];
	logic [AddrW-1:0] peer_addr;
	logic [LenW-1:0]  wr_len, rd_len, wr_left, rd_left;
	logic             wr_on, rd_on, loop_mode;
	logic [1:0]       xfer_st;

	result_t due_results [$];
	result_t seen, want;
	int      bad_count;
	int      result_no;

	function automatic result_t advance_sequencer(input logic [1:0] k, input logic [4:0] f,
			input logic [7:0] d, input logic [7:0] li);
		result_t         r;
		logic            fault;
		logic            w_fin, r_fin;
		logic [LenW-1:0] pos;
		r = '0;
		fault = 1'b0;
		if (k == KindStart) begin
			// no counter reload here
			xfer_st = TsBusy;
			r.request_start = 1'b1;
		end else if (k == KindLoad) begin
			tx_bytes[li] = d;
		end else if (k == KindEvent && f != '0 && xfer_st != TsError) begin
			if (wr_on) begin
				if (f[FlagSb]) begin
					r.send_valid = 1'b1;
					r.send_byte = {peer_addr, 1'b0};
				end else if (f[FlagAddr]) begin
					r.buffer_irq_control = CtlOn;
				end else if (f[FlagRxne]) begin
					// rx not empty is ignored while writing
				end else if (f[FlagTxe] && wr_left != '0) begin
					if (wr_left > wr_len) begin
						fault = 1'b1;
					end else begin
						pos = wr_len - wr_left;
						r.send_valid = 1'b1;
						r.send_byte = tx_bytes[pos[7:0]];
						wr_left = wr_left - 1'b1;
					end
				end else if (f[FlagTxe] && f[FlagBtf]) begin
					r.buffer_irq_control = CtlOff;
					if (rd_on && rd_left != '0)
						r.request_start = 1'b1;
					else
						r.request_stop = 1'b1;
					wr_on = 1'b0;
				end
			end else if (rd_on) begin
				if (f[FlagSb]) begin
					r.send_valid = 1'b1;
					r.send_byte = {peer_addr, 1'b1};
				end else if (f[FlagAddr]) begin
					r.ack_control = CtlOn;
					r.buffer_irq_control = CtlOn;
					// single-byte read: NACK and stop right after the address
					if (rd_len == 9'd1) begin
						if (rd_left > rd_len || rd_left == '0) begin
							fault = 1'b1;
						end else begin
							r.ack_control = CtlOff;
							r.request_stop = 1'b1;
						end
					end
				end else if (f[FlagRxne] && rd_left != '0) begin
					if (rd_left > rd_len) begin
						fault = 1'b1;
					end else begin
						if (rd_left == 9'd2) begin
							r.ack_control = CtlOff;
							r.request_stop = 1'b1;
						end
						pos = rd_len - rd_left;
						r.recv_valid = 1'b1;
						r.recv_index = pos[7:0];
						r.recv_byte = d;
						rd_left = rd_left - 1'b1;
						if (rd_left == '0) begin
							r.buffer_irq_control = CtlOff;
							rd_on = 1'b0;
						end
					end
				end
			end

			if (fault) begin
				xfer_st = TsError;
			end else begin
				w_fin = !wr_on || wr_left == '0;
				r_fin = !rd_on || rd_left == '0;
				if (w_fin && r_fin && xfer_st == TsBusy) begin
					xfer_st = TsDone;
					r.done_pulse = 1'b1;
					if (loop_mode) begin
						wr_left = wr_len;
						wr_on = wr_len != '0;
						rd_left = rd_len;
						rd_on = rd_len != '0;
						xfer_st = TsBusy;
						r.request_start = 1'b1;
					end
				end
			end
		end
		r.transfer_state = xfer_st;
		return r;
	endfunction

	function automatic string show(input result_t r);
		return $sformatf("send %0b/%02h start %0b stop %0b ack %0d irq %0d recv %0b/%0d/%02h state %0d done %0b",
			r.send_valid, r.send_byte, r.request_start, r.request_stop, r.ack_control,
			r.buffer_irq_control, r.recv_valid, r.recv_index, r.recv_byte, r.transfer_state,
			r.done_pulse);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// write store keeps its contents across reset
			peer_addr = SlaveAddrReset;
			wr_len = '0;
			rd_len = '0;
			wr_left = '0;
			rd_left = '0;
			wr_on = 1'b0;
			rd_on = 1'b0;
			loop_mode = 1'b0;
			xfer_st = TsIdle;
			due_results.delete();
			bad_count = 0;
			result_no = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = {send_valid, send_byte, request_start, request_stop, ack_control,
					buffer_irq_control, recv_valid, recv_index, recv_byte, transfer_state,
					done_pulse};
				if (due_results.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("result %0d arrived with nothing expected: %s", result_no,
							show(seen));
				end else begin
					want = due_results.pop_front();
					if (seen !== want) begin
						bad_count++;
						if (bad_count <= 10)
							$display("result %0d mismatch\n  expected %s\n  actual   %s",
								result_no, show(want), show(seen));
					end
				end
				result_no++;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegSlaveAddr: peer_addr = cfg_data[AddrW-1:0];
					RegWriteLen: begin
						wr_len = (cfg_data > MaxBytes) ? MaxBytes : cfg_data;
						wr_left = wr_len;
						wr_on = wr_len != '0;
					end
					RegReadLen: begin
						rd_len = (cfg_data > MaxBytes) ? MaxBytes : cfg_data;
						rd_left = rd_len;
						rd_on = rd_len != '0;
					end
					RegCircular: loop_mode = cfg_data[0];
					default: ;
				endcase
			end

			if (in_valid && in_ready)
				due_results.push_back(advance_sequencer(kind, status_flags, data_byte,
					load_index));

			outstanding <= due_results.size();
			mismatches <= bad_count;
		end
	end

endmodule

// File: test/i2c_master_transfer_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// I2C transfer sequencer testbench
// Drives write/read transfers through the sequencer with random idle gaps on
// both channels and a long receiver hold-off. A directed opening covers the
// byte-count rules, then random phases vary address, lengths and circular
// mode with noise items mixed in. The checker predicts and compares results.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core_tb;
	import i2cseq_pkg::*;

	localparam logic [1:0] KindUnused = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = KindStart;
	logic [4:0]  status_flags = '0;
	logic [7:0]  data_byte = '0;
	logic [7:0]  load_index = '0;

	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = RegSlaveAddr;
	logic [8:0]  cfg_data = '0;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        send_valid;
	logic [7:0]  send_byte;
	logic        request_start;
	logic        request_stop;
	logic [1:0]  ack_control;
	logic [1:0]  buffer_irq_control;
	logic        recv_valid;
	logic [7:0]  recv_index;
	logic [7:0]  recv_byte;
	logic [1:0]  transfer_state;
	logic        done_pulse;

	int          mismatches;
	int          outstanding;

	bit          loaded [StoreDepth];
	int          tx_burst = 0;
	int          work_items = 0;

	i2c_master_transfer_sequencer_core dut (.*);

	i2c_master_transfer_sequencer_core_checker checker_i (.*);

	always #1 clk = ~clk;

	// idle cycles before the next item; occasional runs with no idling
	function automatic int draw_gap(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			run_left = $urandom_range(10, 60);
		return $urandom_range(0, 16);
	endfunction

	function automatic logic [4:0] flag(input int pos);
		return 5'd1 << pos;
	endfunction

	function automatic logic [8:0] pick_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 4)
			return 9'd0;
		if (r == 4)
			return 9'($urandom_range(9, 40));
		return 9'($urandom_range(1, 8));
	endfunction

	// called at a rising edge; returns at the edge that accepts the item
	task automatic send_item(input logic [1:0] k, input logic [4:0] f, input logic [7:0] d,
			input logic [7:0] li);
		int gap;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		status_flags <= f;
		data_byte <= d;
		load_index <= li;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (k == KindLoad)
			loaded[li] = 1'b1;
		if (k != KindUnused && !(k == KindEvent && f == '0))
			work_items++;
	endtask

	// event with flag pos set, random lower-priority flags, plus extra bits
	task automatic send_flag(input int pos, input logic [4:0] extra);
		logic [4:0] fl;
		if ($urandom_range(0, 99) < 10)
			send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
		fl = 5'($urandom_range(0, 31));
		fl = (fl & ~((5'd2 << pos) - 5'd1)) | flag(pos) | extra;
		send_item(KindEvent, fl, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input logic [8:0] addr, input logic [8:0] wl, input logic [8:0] rl,
			input logic [8:0] circ);
		cfg_write(RegSlaveAddr, addr);
		cfg_write(RegWriteLen, wl);
		cfg_write(RegReadLen, rl);
		cfg_write(RegCircular, circ);
		cfg_valid <= 1'b0;
	endtask

	task automatic transfer(input int wbytes, input int rbytes);
		if (wbytes > 0) begin
			send_flag(FlagSb, '0);
			send_flag(FlagAddr, '0);
			repeat (wbytes) send_flag(FlagTxe, '0);
			send_flag(FlagTxe, flag(FlagBtf));
		end
		if (rbytes > 0) begin
			send_flag(FlagSb, '0);
			send_flag(FlagAddr, '0);
			repeat (rbytes) send_flag(FlagRxne, '0);
		end
	endtask

	task automatic run_phase(input logic [8:0] addr, input logic [8:0] wl, input logic [8:0] rl,
			input logic [8:0] circ, input int rounds);
		int wbytes, rbytes;
		wbytes = int'((wl > MaxBytes) ? MaxBytes : wl);
		rbytes = int'((rl > MaxBytes) ? MaxBytes : rl);
		settle();
		configure(addr, wl, rl, circ);
		// every store entry the write phase can fetch must hold data
		for (int i = 0; i < wbytes; i++)
			if (!loaded[i])
				send_item(KindLoad, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
					i[7:0]);
		if (circ[0]) begin
			send_item(KindStart, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			repeat (rounds) transfer(wbytes, rbytes);
		end else begin
			repeat (rounds) begin
				send_item(KindStart, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)));
				transfer(wbytes, rbytes);
			end
		end
	endtask

	// result sink with random stalls and a long hold-off now and then
	initial begin
		int hold, rx_burst, rx_seen;
		rx_burst = 0;
		rx_seen = 0;
		forever begin
			if (rx_seen % 500 == 250)
				hold = 200;
			else
				hold = draw_gap(rx_burst);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			rx_seen++;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// idle block: empty event, unused kind
		send_item(KindEvent, '0, 8'hFF, 8'hFF);
		send_item(KindUnused, '1, 8'h00, 8'h00);

		// two-byte write, single-byte read, top address
		settle();
		configure(9'd127, 9'd2, 9'd1, 9'd0);
		send_item(KindLoad, '1, 8'hFF, 8'd0);
		send_item(KindLoad, '0, 8'h00, 8'd1);
		send_item(KindLoad, '0, 8'h5A, 8'd255);
		send_item(KindStart, '0, 8'h00, 8'h00);
		send_item(KindEvent, '1, 8'h00, 8'h00);
		send_item(KindEvent, '1 & ~flag(FlagSb), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagTxe), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagTxe) | flag(FlagBtf), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagTxe), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagTxe) | flag(FlagBtf), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagSb), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagAddr), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagRxne), 8'hFF, 8'h00);

		// two-byte read only, address zero, circular restart
		settle();
		configure(9'd0, 9'd0, 9'd2, 9'd1);
		send_item(KindStart, '0, 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagSb), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagAddr), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagRxne), 8'h00, 8'h00);
		send_item(KindEvent, flag(FlagRxne) | flag(FlagBtf), 8'h80, 8'h00);
		send_item(KindStart, '1, 8'h00, 8'h00);
		send_item(KindEvent, '1, 8'h00, 8'h00);

		work_items = 0;
		// saturated write length and full-length read in circular mode
		run_phase(9'($urandom_range(0, 511)), 9'd511, 9'd256, 9'd1, 1);
		while (work_items < 1200)
			run_phase(9'($urandom_range(0, 511)), pick_len(), pick_len(),
				9'($urandom_range(0, 511)), $urandom_range(1, 3));

		settle();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("i2c_master_transfer_sequencer_core regression: pass");
		else
			$display("i2c_master_transfer_sequencer_core regression: fail");
		$finish;
	end

	initial begin
		#2000000;
		$display("i2c_master_transfer_sequencer_core regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/i2cseq_pkg.sv
rtl/i2cseq_front.sv
rtl/i2cseq_queue.sv
rtl/i2cseq_back.sv
rtl/i2c_master_transfer_sequencer_core.sv
test/i2c_master_transfer_sequencer_core_checker.sv
test/i2c_master_transfer_sequencer_core_tb.sv
